[hdl/md5bc_pkg.sv]
package md5bc_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic        new_message;
    logic        final_block;
  } md5bc_in_t;

  typedef struct packed {
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;
  } md5bc_out_t;

  // Round group: selects the boolean function, word order and shift row.
  typedef enum logic [1:0] {
    PH_F = 2'd0,
    PH_G = 2'd1,
    PH_H = 2'd2,
    PH_I = 2'd3
  } md5bc_phase_e;

  localparam int unsigned NumWords  = 16;
  localparam int unsigned NumRounds = 64;

  localparam logic [31:0] IvA = 32'h67452301;
  localparam logic [31:0] IvB = 32'hefcdab89;
  localparam logic [31:0] IvC = 32'h98badcfe;
  localparam logic [31:0] IvD = 32'h10325476;

  localparam logic [31:0] SineK [NumRounds] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Message word used by round r.
  function automatic logic [3:0] msg_idx(logic [5:0] r);
    logic [3:0] rl;
    logic [3:0] idx;
    rl = r[3:0];
    unique case (md5bc_phase_e'(r[5:4]))
      PH_F:    idx = rl;
      PH_G:    idx = rl * 4'd5 + 4'd1;
      PH_H:    idx = rl * 4'd3 + 4'd5;
      PH_I:    idx = rl * 4'd7;
      default: idx = rl;
    endcase
    return idx;
  endfunction

  // Left rotate amount of round r.
  function automatic logic [4:0] rot_amt(logic [5:0] r);
    logic [4:0] s;
    unique case (md5bc_phase_e'(r[5:4]))
      PH_F: begin
        unique case (r[1:0])
          2'd0:    s = 5'd7;
          2'd1:    s = 5'd12;
          2'd2:    s = 5'd17;
          default: s = 5'd22;
        endcase
      end
      PH_G: begin
        unique case (r[1:0])
          2'd0:    s = 5'd5;
          2'd1:    s = 5'd9;
          2'd2:    s = 5'd14;
          default: s = 5'd20;
        endcase
      end
      PH_H: begin
        unique case (r[1:0])
          2'd0:    s = 5'd4;
          2'd1:    s = 5'd11;
          2'd2:    s = 5'd16;
          default: s = 5'd23;
        endcase
      end
      default: begin
        unique case (r[1:0])
          2'd0:    s = 5'd6;
          2'd1:    s = 5'd10;
          2'd2:    s = 5'd15;
          default: s = 5'd21;
        endcase
      end
    endcase
    return s;
  endfunction

endpackage

[hdl/md5_block_compression_top.sv]
// Channel | Direction | Handshake                  | Item
// --------+-----------+----------------------------+-------------------------------
// in      | input     | in_valid_i / in_stall_o    | md5bc_in_t: word, new, final
// out     | output    | out_valid_o / out_stall_i  | md5bc_out_t: digest A..D
//
// Words are taken one per cycle while loading; a block of 16 words is then
// compressed at one round per cycle by the single round unit reading the
// block memory, with in_stall_o high throughout.
// A final block then passes through S_EMIT to move the digest into the output
// register, waiting there while a held digest still occupies that register.
// Reset loads the MD5 initial value and clears word and round counters.
// A digest held by out_stall_i does not block loading the next block; a
// second digest waits (input stalled) until the first one is taken.
module md5_block_compression_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  md5bc_pkg::md5bc_in_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output md5bc_pkg::md5bc_out_t out_item_o
);

  typedef enum logic [1:0] {
    S_LOAD,   // taking message words
    S_RUN,    // 64 rounds
    S_EMIT    // digest waits for the output register
  } state_e;

  state_e      state_q;
  logic [3:0]  word_cnt_q;
  logic [5:0]  rnd_q;
  logic        fin_q;
  logic [31:0] cv_q [4];
  logic [31:0] wa_q, wb_q, wc_q, wd_q;
  logic        out_valid_q;
  md5bc_pkg::md5bc_out_t out_q;

  // Block word memory: one write port (loading), one registered read port.
  logic [31:0] blk_mem [md5bc_pkg::NumWords];
  logic [31:0] rd_data_q;
  logic [3:0]  rd_addr;

  logic in_acc;
  logic last_word;
  logic out_free;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign last_word = (word_cnt_q == 4'd15);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_LOAD);

  // Address one round ahead so data is ready when the round runs. While
  // loading, word 0 is prefetched for round 0.
  always_comb begin
    if (state_q == S_RUN) begin
      rd_addr = md5bc_pkg::msg_idx(rnd_q + 6'd1);
    end else begin
      rd_addr = 4'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      blk_mem[word_cnt_q] <= in_item_i.message_word;
    end
    rd_data_q <= blk_mem[rd_addr];
  end

  // Round datapath
  logic [31:0] fn;
  logic [31:0] sum;
  logic [63:0] rot_dbl;
  logic [31:0] new_b;

  always_comb begin
    unique case (md5bc_pkg::md5bc_phase_e'(rnd_q[5:4]))
      md5bc_pkg::PH_F: fn = (wb_q & wc_q) | (~wb_q & wd_q);
      md5bc_pkg::PH_G: fn = (wd_q & wb_q) | (~wd_q & wc_q);
      md5bc_pkg::PH_H: fn = wb_q ^ wc_q ^ wd_q;
      default:         fn = wc_q ^ (wb_q | ~wd_q);
    endcase
    sum     = wa_q + fn + md5bc_pkg::SineK[rnd_q] + rd_data_q;
    rot_dbl = {32'd0, sum} << md5bc_pkg::rot_amt(rnd_q);
    new_b   = wb_q + (rot_dbl[31:0] | rot_dbl[63:32]);
  end

  // Working registers: loaded from the chaining value, then one round a cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD && in_acc && last_word) begin
      if (in_item_i.new_message && word_cnt_q == 4'd0) begin
        wa_q <= md5bc_pkg::IvA;
        wb_q <= md5bc_pkg::IvB;
        wc_q <= md5bc_pkg::IvC;
        wd_q <= md5bc_pkg::IvD;
      end else begin
        wa_q <= cv_q[0];
        wb_q <= cv_q[1];
        wc_q <= cv_q[2];
        wd_q <= cv_q[3];
      end
    end else if (state_q == S_RUN) begin
      wa_q <= wd_q;
      wb_q <= new_b;
      wc_q <= wb_q;
      wd_q <= wc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && out_free) begin
      out_q.digest_a <= cv_q[0];
      out_q.digest_b <= cv_q[1];
      out_q.digest_c <= cv_q[2];
      out_q.digest_d <= cv_q[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      word_cnt_q  <= 4'd0;
      rnd_q       <= 6'd0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cv_q[0]     <= md5bc_pkg::IvA;
      cv_q[1]     <= md5bc_pkg::IvB;
      cv_q[2]     <= md5bc_pkg::IvC;
      cv_q[3]     <= md5bc_pkg::IvD;
    end else begin
      // A new digest replaces one being taken in the same cycle.
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            word_cnt_q <= word_cnt_q + 4'd1;
            if (word_cnt_q == 4'd0 && in_item_i.new_message) begin
              cv_q[0] <= md5bc_pkg::IvA;
              cv_q[1] <= md5bc_pkg::IvB;
              cv_q[2] <= md5bc_pkg::IvC;
              cv_q[3] <= md5bc_pkg::IvD;
            end
            if (last_word) begin
              fin_q   <= in_item_i.final_block;
              rnd_q   <= 6'd0;
              state_q <= S_RUN;
            end
          end
        end
        S_RUN: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            // Feed-forward: registers after this round are (d, new_b, b, c).
            cv_q[0] <= cv_q[0] + wd_q;
            cv_q[1] <= cv_q[1] + new_b;
            cv_q[2] <= cv_q[2] + wb_q;
            cv_q[3] <= cv_q[3] + wc_q;
            state_q <= fin_q ? S_EMIT : S_LOAD;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state_q <= S_LOAD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Block memory is never written during compression, so no read can race.
  a_run_no_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (word_cnt_q == 4'd0))
    else $error("word counter not at block start during rounds");

  a_rnd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_RUN) |-> (rnd_q == 6'd0))
    else $error("round counter left nonzero outside compression");

  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && rnd_q == 6'd63) |=> (state_q != S_RUN))
    else $error("compression did not end after 64 rounds");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("digest raised outside emit");

endmodule
